// ===== rtl/contiguous_bitmap_allocator_macros.svh =====
// Assertion macros for the contiguous bitmap allocator.
// Used by the RTL files that carry checks; expects clk and rst_n in scope.
`ifndef CONTIGUOUS_BITMAP_ALLOCATOR_MACROS_SVH
`define CONTIGUOUS_BITMAP_ALLOCATOR_MACROS_SVH

`ifndef ASSERT_OFF
// Checks that the property holds at every clock edge outside reset.
`define CBA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("cba assertion failed");
// Checks that the condition implies the consequence in the next cycle.
`define CBA_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("cba next-cycle assertion failed");
`else
`define CBA_ASSERT(lbl, prop)
`define CBA_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// ===== rtl/cba_pkg.sv =====
// Shared types and constants for the contiguous bitmap allocator.
// No dependencies; imported by cba_run_check and the top level.
package cba_pkg;

  localparam int MAP_W  = 64;
  localparam int CNT_W  = 7;
  localparam int POS_W  = 7;
  localparam int STAT_W = 3;

  typedef logic [STAT_W-1:0] status_t;

  localparam status_t STAT_AT_PREF     = 3'd0;
  localparam status_t STAT_FIRST_FIT   = 3'd1;
  localparam status_t STAT_EXHAUSTED   = 3'd2;
  localparam status_t STAT_RELEASED    = 3'd3;
  localparam status_t STAT_REL_IGNORED = 3'd4;

  localparam logic [POS_W-1:0] START_NONE = 7'h7F;

  // Verdict of the shared run checker for one start position.
  typedef struct packed {
    logic fits;  // run lies wholly inside the pool
    logic free;  // no slot of the run is taken
  } run_chk_t;

endpackage

// ===== rtl/cba_run_check.sv =====
// Shared run unit: builds the slot mask for one start and count and tests it
// against the bitmap. Depends on cba_pkg.
module cba_run_check import cba_pkg::*; #(
  parameter int POOL_SIZE = 64
) (
  input  logic [POOL_SIZE-1:0] map_i,
  input  logic [POS_W-1:0]     start_i,
  input  logic [CNT_W-1:0]     count_i,
  output logic [POOL_SIZE-1:0] mask_o,
  output run_chk_t             chk_o
);

  logic [POS_W:0] run_end;

  assign run_end = {1'b0, start_i} + {1'b0, count_i};

  always_comb begin
    for (int i = 0; i < POOL_SIZE; i++) begin
      mask_o[i] = ((POS_W+1)'(i) >= {1'b0, start_i}) && ((POS_W+1)'(i) < run_end);
    end
  end

  assign chk_o.fits = (run_end <= (POS_W+1)'(POOL_SIZE));
  assign chk_o.free = ~|(map_i & mask_o);

endmodule

// ===== rtl/contiguous_bitmap_allocator.sv =====
// Contiguous slot allocator over a bitmap with first-fit search.
// Depends on cba_pkg, cba_run_check and the assertion macro header.
//
// Input channel (in_valid/in_stall): mode 0 claims in_slot_count contiguous
// slots, preferring the run at in_start_pos when it is non-negative, lies in
// the pool and is free; otherwise the lowest free run is taken. Mode 1
// releases the run at in_start_pos. Output channel (out_valid/out_stall)
// returns one item per request: status, granted start (-1 if none) and the
// bitmap after the request.
// One item is handled at a time; in_stall is high from acceptance until the
// result has been loaded into the output register. A single run checker is
// reused each cycle: the evaluation state checks the preferred or released
// run, then a first-fit scan tests one start per cycle. A release or a claim
// taken at its preferred start goes from evaluation straight to the emit
// state; a first-fit claim scans from start zero first. The next item may be
// accepted in the cycle after the result is loaded.
// A stalled result holds in the output register; a finished item then waits
// until the register is free. Reset empties the bitmap and drops any result.
`include "contiguous_bitmap_allocator_macros.svh"

module contiguous_bitmap_allocator import cba_pkg::*; #(
  parameter int POOL_SIZE = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_mode,
  input  logic [CNT_W-1:0]        in_slot_count,
  input  logic signed [POS_W-1:0] in_start_pos,
  output logic                    out_valid,
  input  logic                    out_stall,
  output status_t                 out_status,
  output logic signed [POS_W-1:0] out_granted_start,
  output logic [MAP_W-1:0]        out_occupancy
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  localparam logic [CNT_W:0] POOL_CNT = (CNT_W+1)'(POOL_SIZE);

  logic [1:0]           state_r, state_nxt;
  logic                 mode_r, mode_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [POS_W-1:0]     scan_r, scan_nxt;
  logic [POOL_SIZE-1:0] map_r, map_nxt;
  status_t              res_status_r, res_status_nxt;
  logic [POS_W-1:0]     res_start_r, res_start_nxt;

  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [POS_W-1:0]     out_start_r, out_start_nxt;
  logic [MAP_W-1:0]     out_occ_r, out_occ_nxt;

  logic [POS_W-1:0]     unit_start;
  logic [POOL_SIZE-1:0] unit_mask;
  run_chk_t             unit_chk;
  logic                 cnt_ok;
  logic                 out_free;

  assign unit_start = (state_r == S_SCAN) ? scan_r : pos_r;

  cba_run_check #(.POOL_SIZE(POOL_SIZE)) u_run_check (
    .map_i   (map_r),
    .start_i (unit_start),
    .count_i (cnt_r),
    .mask_o  (unit_mask),
    .chk_o   (unit_chk)
  );

  assign cnt_ok   = (cnt_r != '0) && ({1'b0, cnt_r} <= POOL_CNT);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    cnt_nxt        = cnt_r;
    pos_nxt        = pos_r;
    scan_nxt       = scan_r;
    map_nxt        = map_r;
    res_status_nxt = res_status_r;
    res_start_nxt  = res_start_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_start_nxt  = out_start_r;
    out_occ_nxt    = out_occ_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt  = in_mode;
          cnt_nxt   = in_slot_count;
          pos_nxt   = in_start_pos;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        res_start_nxt = START_NONE;
        state_nxt     = S_EMIT;
        if (mode_r) begin
          if (!pos_r[POS_W-1] && (cnt_r != '0) && unit_chk.fits) begin
            map_nxt        = map_r & ~unit_mask;
            res_status_nxt = STAT_RELEASED;
          end else begin
            res_status_nxt = STAT_REL_IGNORED;
          end
        end else if (!cnt_ok) begin
          res_status_nxt = STAT_EXHAUSTED;
        end else if (!pos_r[POS_W-1] && unit_chk.fits && unit_chk.free) begin
          map_nxt        = map_r | unit_mask;
          res_status_nxt = STAT_AT_PREF;
          res_start_nxt  = pos_r;
        end else begin
          scan_nxt  = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!unit_chk.fits) begin
          res_status_nxt = STAT_EXHAUSTED;
          res_start_nxt  = START_NONE;
          state_nxt      = S_EMIT;
        end else if (unit_chk.free) begin
          map_nxt        = map_r | unit_mask;
          res_status_nxt = STAT_FIRST_FIT;
          res_start_nxt  = scan_r;
          state_nxt      = S_EMIT;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_start_nxt  = res_start_r;
          out_occ_nxt    = MAP_W'(map_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      map_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      map_r       <= map_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    cnt_r        <= cnt_nxt;
    pos_r        <= pos_nxt;
    scan_r       <= scan_nxt;
    res_status_r <= res_status_nxt;
    res_start_r  <= res_start_nxt;
    out_status_r <= out_status_nxt;
    out_start_r  <= out_start_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_granted_start = out_start_r;
  assign out_occupancy     = out_occ_r;

  // The scan only runs for a claim whose count fits the pool.
  `CBA_ASSERT(a_scan_cnt, (state_r != S_SCAN) || (!mode_r && cnt_ok))
  // Results that claim nothing carry the "no start" marker.
  `CBA_ASSERT(a_no_start, !out_valid_r || out_status_r == STAT_AT_PREF ||
    out_status_r == STAT_FIRST_FIT || out_start_r == START_NONE)
  // A granted run always lies inside the pool.
  `CBA_ASSERT(a_grant_fits, (state_r != S_EMIT) || res_start_r == START_NONE ||
    ({1'b0, res_start_r} + {1'b0, cnt_r}) <= POOL_CNT)
  // A finished item is handed to a free output register at the next edge.
  `CBA_ASSERT_NEXT(a_emit_load, state_r == S_EMIT && out_free,
    out_valid_r && state_r == S_IDLE && out_status_r == $past(res_status_r))

endmodule
